@@ hdl/prpv_pkg.sv @@
// Shared types, codes and helper functions for the picture-processor register port.
// No dependencies; every other file in hdl/ except prpv_checker imports this package.
package prpv_pkg;

  // Item function codes (code 3 is unused: it changes no register and returns a zero word)
  typedef enum logic [1:0] {
    FUNC_READ   = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_STATUS = 2'd2
  } func_e;

  // CPU-visible register numbers
  typedef enum logic [2:0] {
    REG_CTRL     = 3'd0,
    REG_MASK     = 3'd1,
    REG_STATUS   = 3'd2,
    REG_OAM_ADDR = 3'd3,
    REG_OAM_DATA = 3'd4,
    REG_SCROLL   = 3'd5,
    REG_ADDR     = 3'd6,
    REG_DATA     = 3'd7
  } reg_e;

  // How the result stage builds the returned word
  typedef enum logic [1:0] {
    RK_ZERO   = 2'd0,
    RK_STATUS = 2'd1,
    RK_SPRITE = 2'd2,
    RK_VRAM   = 2'd3
  } rkind_e;

  // Video address regions
  typedef enum logic [1:0] {
    RG_PATTERN = 2'd0,
    RG_NAME    = 2'd1,
    RG_PALETTE = 2'd2
  } region_e;

  localparam int unsigned VADDR_W   = 15;
  localparam int unsigned PAT_AW    = 13;
  localparam int unsigned NAME_AW   = 11;
  localparam int unsigned PAL_AW    = 5;
  localparam int unsigned SPR_AW    = 8;

  localparam logic [VADDR_W-1:0] STEP_ROW = 15'd32;
  localparam logic [VADDR_W-1:0] STEP_COL = 15'd1;
  localparam logic [5:0]         PAL_PAGE = 6'h3F;
  localparam logic [7:0]         PAL_GREY_MASK = 8'h30;
  localparam logic [7:0]         PAL_FULL_MASK = 8'h3F;

  // Memory access request issued at the accept edge
  typedef struct packed {
    logic               spr_we;
    logic               spr_re;
    logic [SPR_AW-1:0]  spr_addr;
    logic               vram_we;
    logic               vram_re;
    region_e            region;
    logic [PAT_AW-1:0]  pat_addr;
    logic [NAME_AW-1:0] name_addr;
    logic [PAL_AW-1:0]  pal_addr;
    logic [7:0]         wdata;
  } mem_req_t;

  // Registered read data of every memory
  typedef struct packed {
    logic [7:0] spr;
    logic [7:0] pat;
    logic [7:0] name;
    logic [7:0] pal;
  } mem_rsp_t;

  // What the result stage needs to know about one word
  typedef struct packed {
    rkind_e     kind;
    logic [2:0] status;
    logic       grey;
    region_e    region;
  } item_t;

  // Palette index: backdrop entries of the sprite palettes alias the background ones
  function automatic logic [PAL_AW-1:0] pal_index(input logic [PAL_AW-1:0] a);
    logic [PAL_AW-1:0] r;
    r = a;
    if (a[4] && (a[1:0] == 2'b00)) r[4] = 1'b0;
    return r;
  endfunction

  // Nametable index with horizontal mirroring: bit 11 picks the table
  function automatic logic [NAME_AW-1:0] name_index(input logic [13:0] a);
    return {a[11], a[9:0]};
  endfunction

endpackage

@@ hdl/prpv_regs.sv @@
// Register file and access decode: control, mask, status, scroll/address latches, sprite address.
// Depends on prpv_pkg; drives the memory request and the per-word info for the result stage.
module prpv_regs
  import prpv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [1:0] func_i,
  input  logic [2:0] reg_index_i,
  input  logic [7:0] write_data_i,
  input  logic [2:0] status_in_i,
  output mem_req_t   mem_req_o,
  output item_t      item_o
);

  logic [7:0]         ctrl_q, ctrl_d;
  logic [7:0]         mask_q, mask_d;
  logic [2:0]         status_q, status_d;
  logic [VADDR_W-1:0] cur_q, cur_d;
  logic [VADDR_W-1:0] tmp_q, tmp_d;
  logic [2:0]         fine_x_q, fine_x_d;
  logic               toggle_q, toggle_d;
  logic [SPR_AW-1:0]  spr_addr_q, spr_addr_d;

  logic [13:0]        vaddr;
  logic [VADDR_W-1:0] cur_step;
  region_e            region;

  // Address decode of the current video address
  always_comb begin
    vaddr    = cur_q[13:0];
    cur_step = cur_q + (ctrl_q[2] ? STEP_ROW : STEP_COL);
    if (!vaddr[13]) begin
      region = RG_PATTERN;
    end else if (vaddr[13:8] == PAL_PAGE) begin
      region = RG_PALETTE;
    end else begin
      region = RG_NAME;
    end
  end

  // Register updates and memory requests for the accepted word
  always_comb begin
    ctrl_d     = ctrl_q;
    mask_d     = mask_q;
    status_d   = status_q;
    cur_d      = cur_q;
    tmp_d      = tmp_q;
    fine_x_d   = fine_x_q;
    toggle_d   = toggle_q;
    spr_addr_d = spr_addr_q;

    mem_req_o.spr_we    = 1'b0;
    mem_req_o.spr_re    = 1'b0;
    mem_req_o.spr_addr  = spr_addr_q;
    mem_req_o.vram_we   = 1'b0;
    mem_req_o.vram_re   = 1'b0;
    mem_req_o.region    = region;
    mem_req_o.pat_addr  = vaddr[PAT_AW-1:0];
    mem_req_o.name_addr = name_index(vaddr);
    mem_req_o.pal_addr  = pal_index(vaddr[PAL_AW-1:0]);
    mem_req_o.wdata     = write_data_i;

    item_o.kind   = RK_ZERO;
    item_o.status = status_q;
    item_o.grey   = mask_q[0];
    item_o.region = region;

    if (accept_i) begin
      unique case (func_i)
        FUNC_READ: begin
          unique case (reg_index_i)
            REG_STATUS: begin
              item_o.kind = RK_STATUS;
              status_d    = {1'b0, status_q[1:0]};
              toggle_d    = 1'b0;
            end
            REG_OAM_DATA: begin
              item_o.kind      = RK_SPRITE;
              mem_req_o.spr_re = 1'b1;
            end
            REG_DATA: begin
              item_o.kind       = RK_VRAM;
              mem_req_o.vram_re = 1'b1;
              cur_d             = cur_step;
            end
            default: ;
          endcase
        end
        FUNC_WRITE: begin
          unique case (reg_index_i)
            REG_CTRL: begin
              ctrl_d       = write_data_i;
              tmp_d[11:10] = write_data_i[1:0];
            end
            REG_MASK:     mask_d = write_data_i;
            REG_OAM_ADDR: spr_addr_d = write_data_i;
            REG_OAM_DATA: begin
              mem_req_o.spr_we = 1'b1;
              spr_addr_d       = spr_addr_q + 8'd1;
            end
            REG_SCROLL: begin
              if (!toggle_q) begin
                fine_x_d   = write_data_i[2:0];
                tmp_d[4:0] = write_data_i[7:3];
              end else begin
                tmp_d[14:12] = write_data_i[2:0];
                tmp_d[9:5]   = write_data_i[7:3];
              end
              toggle_d = ~toggle_q;
            end
            REG_ADDR: begin
              if (!toggle_q) begin
                tmp_d[14]   = 1'b0;
                tmp_d[13:8] = write_data_i[5:0];
              end else begin
                tmp_d[7:0] = write_data_i;
                cur_d      = {tmp_q[14:8], write_data_i};
              end
              toggle_d = ~toggle_q;
            end
            REG_DATA: begin
              mem_req_o.vram_we = 1'b1;
              cur_d             = cur_step;
            end
            default: ;
          endcase
        end
        FUNC_STATUS: status_d = status_in_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q     <= '0;
      mask_q     <= '0;
      status_q   <= '0;
      cur_q      <= '0;
      tmp_q      <= '0;
      fine_x_q   <= '0;
      toggle_q   <= 1'b0;
      spr_addr_q <= '0;
    end else begin
      ctrl_q     <= ctrl_d;
      mask_q     <= mask_d;
      status_q   <= status_d;
      cur_q      <= cur_d;
      tmp_q      <= tmp_d;
      fine_x_q   <= fine_x_d;
      toggle_q   <= toggle_d;
      spr_addr_q <= spr_addr_d;
    end
  end

endmodule

@@ hdl/prpv_vmem.sv @@
// Sprite, pattern, nametable and palette memories with registered read ports.
// Depends on prpv_pkg; driven by the request from prpv_regs.
module prpv_vmem
  import prpv_pkg::*;
(
  input  logic     clk_i,
  input  mem_req_t mem_req_i,
  output mem_rsp_t mem_rsp_o
);

  logic [7:0] spr_mem  [2**SPR_AW];
  logic [7:0] pat_mem  [2**PAT_AW];
  logic [7:0] name_mem [2**NAME_AW];
  logic [7:0] pal_mem  [2**PAL_AW];

  logic [7:0] spr_rd_q, pat_rd_q, name_rd_q, pal_rd_q;

  // Sprite memory
  always_ff @(posedge clk_i) begin
    if (mem_req_i.spr_we) spr_mem[mem_req_i.spr_addr] <= mem_req_i.wdata;
    if (mem_req_i.spr_re) spr_rd_q <= spr_mem[mem_req_i.spr_addr];
  end

  // Pattern memory
  always_ff @(posedge clk_i) begin
    if (mem_req_i.vram_we && (mem_req_i.region == RG_PATTERN)) begin
      pat_mem[mem_req_i.pat_addr] <= mem_req_i.wdata;
    end
    if (mem_req_i.vram_re) pat_rd_q <= pat_mem[mem_req_i.pat_addr];
  end

  // Nametable memory
  always_ff @(posedge clk_i) begin
    if (mem_req_i.vram_we && (mem_req_i.region == RG_NAME)) begin
      name_mem[mem_req_i.name_addr] <= mem_req_i.wdata;
    end
    if (mem_req_i.vram_re) name_rd_q <= name_mem[mem_req_i.name_addr];
  end

  // Palette memory
  always_ff @(posedge clk_i) begin
    if (mem_req_i.vram_we && (mem_req_i.region == RG_PALETTE)) begin
      pal_mem[mem_req_i.pal_addr] <= mem_req_i.wdata;
    end
    if (mem_req_i.vram_re) pal_rd_q <= pal_mem[mem_req_i.pal_addr];
  end

  assign mem_rsp_o.spr  = spr_rd_q;
  assign mem_rsp_o.pat  = pat_rd_q;
  assign mem_rsp_o.name = name_rd_q;
  assign mem_rsp_o.pal  = pal_rd_q;

endmodule

@@ hdl/prpv_resp.sv @@
// Result stage: read buffer, result formation and output register with stall handling.
// Depends on prpv_pkg; consumes item info from prpv_regs and read data from prpv_vmem.
module prpv_resp
  import prpv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  item_t      item_i,
  input  mem_rsp_t   mem_rsp_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o
);

  logic       b_valid_q;
  item_t      b_item_q;
  logic [7:0] rbuf_q, rbuf_d;
  logic       out_valid_q;
  logic [7:0] out_data_q;

  logic       out_free;
  logic       b_adv;
  logic [7:0] vdata;
  logic [7:0] result;

  // Handshake: stage B moves on when the output register is free
  assign out_free   = !out_valid_q || !out_stall_i;
  assign b_adv      = b_valid_q && out_free;
  assign in_ready_o = !b_valid_q || out_free;

  // Result word and next read buffer
  always_comb begin
    case (b_item_q.region)
      RG_PALETTE: vdata = mem_rsp_i.pal & (b_item_q.grey ? PAL_GREY_MASK : PAL_FULL_MASK);
      RG_NAME:    vdata = mem_rsp_i.name;
      default:    vdata = mem_rsp_i.pat;
    endcase
    rbuf_d = rbuf_q;
    unique case (b_item_q.kind)
      RK_STATUS: result = {b_item_q.status, rbuf_q[4:0]};
      RK_SPRITE: result = mem_rsp_i.spr;
      RK_VRAM: begin
        // palette reads bypass the one-read delay
        result = (b_item_q.region == RG_PALETTE) ? vdata : rbuf_q;
        rbuf_d = vdata;
      end
      default:   result = 8'd0;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      rbuf_q      <= '0;
    end else begin
      b_valid_q <= accept_i || (b_valid_q && !b_adv);
      if (b_adv) begin
        out_valid_q <= 1'b1;
        rbuf_q      <= rbuf_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept_i) b_item_q <= item_i;
    if (b_adv) out_data_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;

endmodule

@@ hdl/ppu_register_port_vram_unit.sv @@
// Picture-processor CPU register port with video memory: one bus access per word, one read
// byte back per word. An accepted word updates the registers and starts its memory access at
// the accept edge. Its result is formed in the result stage from the synchronous memory read
// register, where the data-port read buffer is also updated, and then enters the output
// register. A new word can be accepted every cycle while the output is taken.
// Memories are not cleared at reset; a read of a never-written entry returns unknown data.
// Depends on prpv_pkg, prpv_regs, prpv_vmem and prpv_resp.
module ppu_register_port_vram_unit
  import prpv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] func_i,
  input  logic [2:0] reg_index_i,
  input  logic [7:0] write_data_i,
  input  logic [2:0] status_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o
);

  logic     in_ready;
  logic     accept;
  mem_req_t mem_req;
  mem_rsp_t mem_rsp;
  item_t    item;

  assign accept     = in_valid_i && in_ready;
  assign in_stall_o = !in_ready;

  prpv_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .func_i       (func_i),
    .reg_index_i  (reg_index_i),
    .write_data_i (write_data_i),
    .status_in_i  (status_in_i),
    .mem_req_o    (mem_req),
    .item_o       (item)
  );

  prpv_vmem u_vmem (
    .clk_i     (clk_i),
    .mem_req_i (mem_req),
    .mem_rsp_o (mem_rsp)
  );

  prpv_resp u_resp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (item),
    .mem_rsp_i   (mem_rsp),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .read_data_o (read_data_o)
  );

endmodule

@@ hdl/prpv_checker.sv @@
// Port-level checks for ppu_register_port_vram_unit, attached by the bind at the end.
// No package dependency; sees the top-level ports only.
module prpv_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] read_data_o
);

  // A stalled result word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its data
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(read_data_o))
    else $error("result data changed while stalled");

  // With the output register empty the input side is never stalled
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // A fresh result word comes from an accepted input word that did not wait in stage B
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result word without an accepted input word");

endmodule

bind ppu_register_port_vram_unit prpv_checker u_prpv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .read_data_o (read_data_o)
);
